[hdl/hbck_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbck_pkg
// Shared types, constants and helpers for the half-blend color-key blitter.
// ----------------------------------------------------------------------------
package hbck_pkg;

  localparam int unsigned MaxWidth   = 64;
  localparam int unsigned MaxHeight  = 64;
  localparam int unsigned StoreDepth = MaxWidth * MaxHeight;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned PixW       = 16;
  localparam int unsigned DimW       = 7;
  localparam int unsigned CoordW     = 6;
  localparam int unsigned PaddrW     = 5;

  localparam logic [DimW-1:0] MaxWidthV  = DimW'(MaxWidth);
  localparam logic [DimW-1:0] MaxHeightV = DimW'(MaxHeight);

  // command codes
  localparam logic [1:0] CmdWrSrc  = 2'd0;
  localparam logic [1:0] CmdWrDst  = 2'd1;
  localparam logic [1:0] CmdRdDst  = 2'd2;
  localparam logic [1:0] CmdBlit   = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [11:0]       address;
    logic [PixW-1:0]   pixel;
    logic [CoordW-1:0] src_col;
    logic [CoordW-1:0] src_row;
    logic [CoordW-1:0] dst_col;
    logic [CoordW-1:0] dst_row;
    logic [DimW-1:0]   rect_width;
    logic [DimW-1:0]   rect_height;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] read_pixel;
    logic            status;
  } out_item_t;

  typedef struct packed {
    logic [DimW-1:0] src_row_pixels;
    logic [DimW-1:0] src_rows;
    logic [DimW-1:0] dst_row_pixels;
    logic [DimW-1:0] dst_rows;
    logic            key_enable;
    logic [PixW-1:0] key_color;
  } cfg_t;

  typedef struct packed {
    logic             src_we;
    logic [AddrW-1:0] src_waddr;
    logic [PixW-1:0]  src_wdata;
    logic             src_re;
    logic [AddrW-1:0] src_raddr;
    logic             dst_we;
    logic [AddrW-1:0] dst_waddr;
    logic [PixW-1:0]  dst_wdata;
    logic             dst_re;
    logic [AddrW-1:0] dst_raddr;
  } mem_req_t;

  typedef struct packed {
    logic idle;
    logic resp;
    logic pipe_wr;
  } seq_stat_t;

  // saturate an image dimension at the store maximum
  function automatic logic [DimW-1:0] lim_dim(input logic [DimW-1:0] v,
                                              input logic [DimW-1:0] max_v);
    lim_dim = (v > max_v) ? max_v : v;
  endfunction

  function automatic logic [DimW-1:0] min_dim(input logic [DimW-1:0] a,
                                              input logic [DimW-1:0] b);
    min_dim = (a < b) ? a : b;
  endfunction

endpackage
`default_nettype wire

[hdl/hbck_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbck_cfg
// APB-style register file: image sizes and color key settings.
// ----------------------------------------------------------------------------
module hbck_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hbck_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output hbck_pkg::cfg_t             cfg_o
);
  import hbck_pkg::*;

  localparam logic [2:0] RegSrcW  = 3'd0;
  localparam logic [2:0] RegSrcH  = 3'd1;
  localparam logic [2:0] RegDstW  = 3'd2;
  localparam logic [2:0] RegDstH  = 3'd3;
  localparam logic [2:0] RegKeyEn = 3'd4;
  localparam logic [2:0] RegKey   = 3'd5;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegSrcW:  cfg_d.src_row_pixels = pwdata[DimW-1:0];
        RegSrcH:  cfg_d.src_rows       = pwdata[DimW-1:0];
        RegDstW:  cfg_d.dst_row_pixels = pwdata[DimW-1:0];
        RegDstH:  cfg_d.dst_rows       = pwdata[DimW-1:0];
        RegKeyEn: cfg_d.key_enable     = pwdata[0];
        RegKey:   cfg_d.key_color      = pwdata[PixW-1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegSrcW:  prdata = 32'(cfg_q.src_row_pixels);
      RegSrcH:  prdata = 32'(cfg_q.src_rows);
      RegDstW:  prdata = 32'(cfg_q.dst_row_pixels);
      RegDstH:  prdata = 32'(cfg_q.dst_rows);
      RegKeyEn: prdata = 32'(cfg_q.key_enable);
      RegKey:   prdata = 32'(cfg_q.key_color);
      default:  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_row_pixels <= MaxWidthV;
      cfg_q.src_rows       <= MaxHeightV;
      cfg_q.dst_row_pixels <= MaxWidthV;
      cfg_q.dst_rows       <= MaxHeightV;
      cfg_q.key_enable     <= 1'b0;
      cfg_q.key_color      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[hdl/hbck_blend.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbck_blend
// Per-channel RGB565 half blend with color key compare.
// ----------------------------------------------------------------------------
module hbck_blend (
  input  logic [hbck_pkg::PixW-1:0] src_i,
  input  logic [hbck_pkg::PixW-1:0] dst_i,
  input  logic                      key_en_i,
  input  logic [hbck_pkg::PixW-1:0] key_i,
  output logic [hbck_pkg::PixW-1:0] res_o,
  output logic                      skip_o
);
  import hbck_pkg::*;

  logic [5:0] sum_r;
  logic [6:0] sum_g;
  logic [5:0] sum_b;

  assign sum_r = {1'b0, src_i[15:11]} + {1'b0, dst_i[15:11]};
  assign sum_g = {1'b0, src_i[10:5]}  + {1'b0, dst_i[10:5]};
  assign sum_b = {1'b0, src_i[4:0]}   + {1'b0, dst_i[4:0]};

  // drop the low bit of each sum: average rounded down
  assign res_o  = {sum_r[5:1], sum_g[6:1], sum_b[5:1]};
  assign skip_o = key_en_i && (src_i == key_i);

endmodule
`default_nettype wire

[hdl/hbck_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbck_mem
// Source and destination pixel stores, one write and one read port each,
// registered read data.
// ----------------------------------------------------------------------------
module hbck_mem (
  input  logic                      clk_i,
  input  hbck_pkg::mem_req_t        req_i,
  output logic [hbck_pkg::PixW-1:0] src_rdata_o,
  output logic [hbck_pkg::PixW-1:0] dst_rdata_o
);
  import hbck_pkg::*;

  logic [PixW-1:0] src_mem [StoreDepth];
  logic [PixW-1:0] dst_mem [StoreDepth];
  logic [PixW-1:0] src_rdata_q;
  logic [PixW-1:0] dst_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.src_we) begin
      src_mem[req_i.src_waddr] <= req_i.src_wdata;
    end
    if (req_i.src_re) begin
      src_rdata_q <= src_mem[req_i.src_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.dst_we) begin
      dst_mem[req_i.dst_waddr] <= req_i.dst_wdata;
    end
    if (req_i.dst_re) begin
      dst_rdata_q <= dst_mem[req_i.dst_raddr];
    end
  end

  assign src_rdata_o = src_rdata_q;
  assign dst_rdata_o = dst_rdata_q;

endmodule
`default_nettype wire

[hdl/hbck_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbck_seq
// Command sequencer: store access, overlay clipping and the pixel walk that
// drives the shared blend unit, plus the result register.
// ----------------------------------------------------------------------------
module hbck_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hbck_pkg::cfg_t            cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  hbck_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output hbck_pkg::out_item_t       out_data_o,
  output hbck_pkg::mem_req_t        mem_req_o,
  input  logic [hbck_pkg::PixW-1:0] src_rdata_i,
  input  logic [hbck_pkg::PixW-1:0] dst_rdata_i,
  output hbck_pkg::seq_stat_t       stat_o
);
  import hbck_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StClip = 3'd1;
  localparam logic [2:0] StBase = 3'd2;
  localparam logic [2:0] StRun  = 3'd3;
  localparam logic [2:0] StResp = 3'd4;

  logic [2:0]        state_q, state_d;
  in_item_t          item_q;
  logic              status_q, status_d;
  logic              out_valid_q;
  out_item_t         out_data_q;

  logic [DimW-1:0]   sw_q, dw_q;
  logic [CoordW-1:0] w_m1_q, h_m1_q;
  logic [CoordW-1:0] col_q, row_q;
  logic [AddrW-1:0]  src_base_q, dst_base_q;
  logic [AddrW-1:0]  src_addr_q, dst_addr_q;
  logic              p_vld_q;
  logic [AddrW-1:0]  p_addr_q;

  logic              accept;
  logic              out_load;
  logic [DimW-1:0]   sw, sh, dw, dh;
  logic              reject;
  logic [DimW-1:0]   cw, ch;
  logic [12:0]       src_prod, dst_prod;
  logic [AddrW-1:0]  src_base_n, dst_base_n;
  logic [PixW-1:0]   blend_res;
  logic              blend_skip;

  assign accept   = in_valid_i && in_ready_o;
  assign out_load = (state_q == StResp) && (!out_valid_q || out_ready_i);

  // image limits and clipping
  assign sw = lim_dim(cfg_i.src_row_pixels, MaxWidthV);
  assign sh = lim_dim(cfg_i.src_rows, MaxHeightV);
  assign dw = lim_dim(cfg_i.dst_row_pixels, MaxWidthV);
  assign dh = lim_dim(cfg_i.dst_rows, MaxHeightV);

  assign reject = ({1'b0, item_q.dst_col} >= dw) || ({1'b0, item_q.dst_row} >= dh) ||
                  ({1'b0, item_q.src_col} >= sw) || ({1'b0, item_q.src_row} >= sh);

  assign cw = min_dim(item_q.rect_width,
                      min_dim(dw - {1'b0, item_q.dst_col}, sw - {1'b0, item_q.src_col}));
  assign ch = min_dim(item_q.rect_height,
                      min_dim(dh - {1'b0, item_q.dst_row}, sh - {1'b0, item_q.src_row}));

  // start address of the first row: row times width plus column
  assign src_prod = 13'(item_q.src_row) * 13'(sw_q);
  assign dst_prod = 13'(item_q.dst_row) * 13'(dw_q);
  assign src_base_n = AddrW'(src_prod + 13'(item_q.src_col));
  assign dst_base_n = AddrW'(dst_prod + 13'(item_q.dst_col));

  hbck_blend u_blend (
    .src_i    (src_rdata_i),
    .dst_i    (dst_rdata_i),
    .key_en_i (cfg_i.key_enable),
    .key_i    (cfg_i.key_color),
    .res_o    (blend_res),
    .skip_o   (blend_skip)
  );

  always_comb begin
    mem_req_o           = '0;
    mem_req_o.src_waddr = in_data_i.address;
    mem_req_o.src_wdata = in_data_i.pixel;
    mem_req_o.src_we    = accept && (in_data_i.cmd == CmdWrSrc);
    mem_req_o.src_raddr = src_addr_q;
    mem_req_o.src_re    = (state_q == StRun);
    if (accept) begin
      mem_req_o.dst_we    = (in_data_i.cmd == CmdWrDst);
      mem_req_o.dst_waddr = in_data_i.address;
      mem_req_o.dst_wdata = in_data_i.pixel;
      mem_req_o.dst_re    = (in_data_i.cmd == CmdRdDst);
      mem_req_o.dst_raddr = in_data_i.address;
    end else begin
      mem_req_o.dst_we    = p_vld_q && !blend_skip;
      mem_req_o.dst_waddr = p_addr_q;
      mem_req_o.dst_wdata = blend_res;
      mem_req_o.dst_re    = (state_q == StRun);
      mem_req_o.dst_raddr = dst_addr_q;
    end
  end

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          status_d = 1'b0;
          state_d  = (in_data_i.cmd == CmdBlit) ? StClip : StResp;
        end
      end
      StClip: begin
        if (reject) begin
          status_d = 1'b1;
          state_d  = StResp;
        end else if ((cw == '0) || (ch == '0)) begin
          state_d = StResp;
        end else begin
          state_d = StBase;
        end
      end
      StBase: state_d = StRun;
      StRun: begin
        if ((col_q == w_m1_q) && (row_q == h_m1_q)) begin
          state_d = StResp;
        end
      end
      StResp: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      status_q    <= 1'b0;
      out_valid_q <= 1'b0;
      p_vld_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      p_vld_q  <= (state_q == StRun);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (out_load) begin
      out_data_q.read_pixel <= (item_q.cmd == CmdRdDst) ? dst_rdata_i : '0;
      out_data_q.status     <= status_q;
    end
    p_addr_q <= dst_addr_q;
    unique case (state_q)
      StClip: begin
        sw_q   <= sw;
        dw_q   <= dw;
        w_m1_q <= CoordW'(cw - 7'd1);
        h_m1_q <= CoordW'(ch - 7'd1);
      end
      StBase: begin
        col_q      <= '0;
        row_q      <= '0;
        src_base_q <= src_base_n;
        dst_base_q <= dst_base_n;
        src_addr_q <= src_base_n;
        dst_addr_q <= dst_base_n;
      end
      StRun: begin
        if (col_q == w_m1_q) begin
          // advance to the next row
          col_q      <= '0;
          row_q      <= row_q + 1'b1;
          src_base_q <= src_base_q + AddrW'(sw_q);
          dst_base_q <= dst_base_q + AddrW'(dw_q);
          src_addr_q <= src_base_q + AddrW'(sw_q);
          dst_addr_q <= dst_base_q + AddrW'(dw_q);
        end else begin
          col_q      <= col_q + 1'b1;
          src_addr_q <= src_addr_q + 1'b1;
          dst_addr_q <= dst_addr_q + 1'b1;
        end
      end
      default: begin
        col_q <= col_q;
      end
    endcase
  end

  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign stat_o.idle    = (state_q == StIdle);
  assign stat_o.resp    = (state_q == StResp);
  assign stat_o.pipe_wr = p_vld_q;

endmodule
`default_nettype wire

[hdl/half_blend_color_key_blit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// half_blend_color_key_blit
// RGB565 blitter: source and destination stores, 50% blend with color key.
//
// Commands arrive on the input channel (valid/ready), one result per command
// leaves on the output channel (valid/ready) through a result register.
// Image sizes and the key are set through the APB-style port only while idle;
// the user must keep to this, the block itself does not enforce it. Write and
// read commands pass through the response state; the next command is taken
// the cycle after the result is loaded. Overlay: a clip state, then a rejected
// or empty overlay answers at once; otherwise a base-address state and one
// pixel per cycle over the clipped rectangle. The single blend unit and the
// one destination write port set the pixel rate.
// Reset clears the sequencer and the registers to 64x64 images, key off;
// store contents stay undefined until written.
// A stalled receiver holds the result; a finished command waits in its
// response state and no new command is taken until the result register frees.
// ----------------------------------------------------------------------------
module half_blend_color_key_blit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hbck_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  hbck_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output hbck_pkg::out_item_t         out_data_o
);
  import hbck_pkg::*;

  cfg_t            cfg;
  mem_req_t        mem_req;
  seq_stat_t       stat;
  logic [PixW-1:0] src_rdata;
  logic [PixW-1:0] dst_rdata;

  hbck_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hbck_mem u_mem (
    .clk_i       (clk_i),
    .req_i       (mem_req),
    .src_rdata_o (src_rdata),
    .dst_rdata_o (dst_rdata)
  );

  hbck_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_req_o   (mem_req),
    .src_rdata_i (src_rdata),
    .dst_rdata_i (dst_rdata),
    .stat_o      (stat)
  );

  // after a transfer the sequencer is not ready for the next command at once
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken on consecutive cycles");

  // a blend write-back never collides with a command taking the store port
  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.pipe_wr && in_ready_o))
    else $error("blend write-back while idle");

  // loading the result from the response state makes it valid and returns the sequencer to idle
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.resp && (!out_valid_o || out_ready_i)) |=> (out_valid_o && stat.idle))
    else $error("result not loaded from response state");

endmodule
`default_nettype wire
